[src/pfdm_pkg.sv]
// Package for the pulse frequency and duty meter.
// Holds field widths, reset constants, and the command and status structs
// shared by the controller and the datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfdm_pkg;

  localparam int unsigned FreqBits           = 27;
  localparam int unsigned DutyBits           = 7;
  localparam int unsigned ClockBits          = 27;
  localparam int unsigned CounterBitsDefault = 16;
  localparam int unsigned DutyScale          = 100;
  localparam logic [ClockBits-1:0] ClockResetHz = 27'd16000000;

  // The shared divider must hold both the clock dividend and high * 100.
  function automatic int unsigned div_bits(input int unsigned counter_bits);
    int unsigned duty_width;
    duty_width = counter_bits + DutyBits;
    div_bits = (duty_width > FreqBits) ? duty_width : FreqBits;
  endfunction

  typedef struct packed {
    logic accept;       // input request taken this cycle
    logic cap_rise;     // store the counter as the first rising edge time
    logic cap_fall;     // store the counter as the falling edge time
    logic cap_second;   // compute period and high time from the counter
    logic clr_cnt;      // restart the tick counter instead of advancing it
    logic set_invalid;  // load an out-of-range result
    logic load_freq;    // load the divider with the clock rate
    logic load_duty;    // load the divider with high time times 100
    logic div_step;     // one restoring division step
    logic save_freq;    // keep the quotient as the frequency
    logic save_duty;    // keep the quotient as the duty cycle
  } ctrl_cmd_t;

  typedef struct packed {
    logic rise;
    logic fall;
    logic order_ok;
  } dp_status_t;

endpackage

`default_nettype wire

[src/pfdm_if.sv]
// Valid/ready channel interfaces for the pulse frequency and duty meter.
// Depends on pfdm_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pfdm_in_if;
  logic valid;
  logic ready;
  logic signal_level;

  modport source (output valid, output signal_level, input ready);
  modport sink (input valid, input signal_level, output ready);
endinterface

interface pfdm_out_if;
  logic                            valid;
  logic                            ready;
  logic [pfdm_pkg::FreqBits-1:0]   frequency_hz;
  logic [pfdm_pkg::DutyBits-1:0]   duty_percent;
  logic                            out_of_range;

  modport source (output valid, output frequency_hz, output duty_percent,
                  output out_of_range, input ready);
  modport sink (input valid, input frequency_hz, input duty_percent,
                input out_of_range, output ready);
endinterface

`default_nettype wire

[src/pulse_frequency_duty_meter.sv]
// Pulse frequency and duty meter. Each accepted input request is one sample
// of the pulse; a COUNTER_BITS tick counter times a rising edge, the next
// falling edge and the next rising edge, and one result request reports
// clock_hz / period and floor(high * 100 / period), or out_of_range when the
// captures are out of order because the counter wrapped. Samples that do
// not close a measurement can be taken back to back. After a sample that
// closes a valid measurement, the one bit-serial divider, D = max(27,
// COUNTER_BITS + 7) bits wide, computes the frequency and then the duty
// before the result is offered; for an invalid measurement the result is
// offered in the next cycle. No sample is taken while a result waits.
// Depends on pfdm_pkg, pfdm_if, pfdm_ctrl and pfdm_dp.
`timescale 1ns / 1ps
`default_nettype none

module pulse_frequency_duty_meter #(
  parameter int unsigned COUNTER_BITS = pfdm_pkg::CounterBitsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pfdm_pkg::ClockBits-1:0] cfg_wdata_i,
  pfdm_in_if.sink                             in_i,
  pfdm_out_if.source                          out_o
);

  pfdm_pkg::ctrl_cmd_t  cmd;
  pfdm_pkg::dp_status_t status;
  logic                 in_ready;
  logic                 out_valid;

  pfdm_ctrl #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pfdm_dp #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .level_i     (in_i.signal_level),
    .cmd_i       (cmd),
    .status_o    (status),
    .freq_o      (out_o.frequency_hz),
    .duty_o      (out_o.duty_percent),
    .oor_o       (out_o.out_of_range)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule

`default_nettype wire

[src/pfdm_ctrl.sv]
// Controller of the pulse frequency and duty meter: measurement phases,
// divider sequencing and the result handshake. Depends on pfdm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfdm_ctrl #(
  parameter int unsigned COUNTER_BITS = pfdm_pkg::CounterBitsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire pfdm_pkg::dp_status_t status_i,
  output pfdm_pkg::ctrl_cmd_t       cmd_o
);

  localparam int unsigned DivBits  = pfdm_pkg::div_bits(COUNTER_BITS);
  localparam int unsigned StepBits = $clog2(DivBits + 1);
  localparam logic [StepBits-1:0] LastStep = StepBits'(DivBits);

  typedef enum logic [2:0] {
    ST_RISE1,
    ST_FALL,
    ST_RISE2,
    ST_FREQ,
    ST_DUTY,
    ST_OUT
  } state_e;

  state_e              state_q;
  logic [StepBits-1:0] step_q;
  logic                accept;
  logic                step_done;

  assign in_ready_o  = (state_q == ST_RISE1) || (state_q == ST_FALL) ||
                       (state_q == ST_RISE2);
  assign out_valid_o = (state_q == ST_OUT);
  assign accept      = in_valid_i && in_ready_o;
  assign step_done   = (step_q == LastStep);

  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = accept;
    unique case (state_q)
      ST_RISE1: begin
        cmd_o.cap_rise = accept && status_i.rise;
      end
      ST_FALL: begin
        cmd_o.cap_fall = accept && status_i.fall;
      end
      ST_RISE2: begin
        if (accept && status_i.rise) begin
          cmd_o.cap_second  = 1'b1;
          cmd_o.clr_cnt     = 1'b1;
          cmd_o.load_freq   = status_i.order_ok;
          cmd_o.set_invalid = !status_i.order_ok;
        end
      end
      ST_FREQ: begin
        cmd_o.div_step  = !step_done;
        cmd_o.save_freq = step_done;
        cmd_o.load_duty = step_done;
      end
      ST_DUTY: begin
        cmd_o.div_step  = !step_done;
        cmd_o.save_duty = step_done;
      end
      ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RISE1;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        ST_RISE1: begin
          if (accept && status_i.rise) state_q <= ST_FALL;
        end
        ST_FALL: begin
          if (accept && status_i.fall) state_q <= ST_RISE2;
        end
        ST_RISE2: begin
          if (accept && status_i.rise) begin
            state_q <= status_i.order_ok ? ST_FREQ : ST_OUT;
            step_q  <= '0;
          end
        end
        ST_FREQ: begin
          if (step_done) begin
            state_q <= ST_DUTY;
            step_q  <= '0;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_DUTY: begin
          if (step_done) begin
            state_q <= ST_OUT;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_OUT: begin
          if (out_ready_i) state_q <= ST_RISE1;
        end
        default: begin
          state_q <= ST_RISE1;
        end
      endcase
    end
  end

  // Input is never taken while a result waits.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= LastStep)
    else $error("divider step count out of range");

  // A result appears only after the duty division or an invalid capture.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_DUTY) || ($past(state_q) == ST_RISE2))
    else $error("result raised from an unexpected state");

  // Both loads of the divider are followed by stepping.
  a_load_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_freq || cmd_o.load_duty) |=> cmd_o.div_step)
    else $error("divider loaded but not stepped");

endmodule

`default_nettype wire

[src/pfdm_dp.sv]
// Datapath of the pulse frequency and duty meter: edge detection, tick
// counter, capture registers, bit-serial divider and result registers.
// Depends on pfdm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfdm_dp #(
  parameter int unsigned COUNTER_BITS = pfdm_pkg::CounterBitsDefault
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [pfdm_pkg::ClockBits-1:0]        cfg_wdata_i,
  input  wire logic                                  level_i,
  input  wire pfdm_pkg::ctrl_cmd_t                   cmd_i,
  output pfdm_pkg::dp_status_t                       status_o,
  output logic [pfdm_pkg::FreqBits-1:0]              freq_o,
  output logic [pfdm_pkg::DutyBits-1:0]              duty_o,
  output logic                                       oor_o
);

  localparam int unsigned CB      = COUNTER_BITS;
  localparam int unsigned DivBits = pfdm_pkg::div_bits(COUNTER_BITS);
  localparam int unsigned ProdBits = CB + pfdm_pkg::DutyBits;

  logic [pfdm_pkg::ClockBits-1:0] clock_q;
  logic                           prev_q;
  logic [CB-1:0]                  cnt_q;
  logic [CB-1:0]                  rise_q;
  logic [CB-1:0]                  fall_q;
  logic [CB-1:0]                  per_q;
  logic [CB-1:0]                  high_q;
  logic [DivBits-1:0]             quo_q;
  logic [CB-1:0]                  rem_q;
  logic [pfdm_pkg::FreqBits-1:0]  freq_q;
  logic [pfdm_pkg::DutyBits-1:0]  duty_q;
  logic                           oor_q;

  logic [CB:0]        rem_sh;
  logic [CB:0]        diff;
  logic               fits;
  logic [ProdBits-1:0] duty_prod;

  assign status_o.rise     = !prev_q && level_i;
  assign status_o.fall     = prev_q && !level_i;
  assign status_o.order_ok = (fall_q > rise_q) && (fall_q < cnt_q);

  // Restoring division, one quotient bit per step.
  assign rem_sh = {rem_q, quo_q[DivBits-1]};
  assign diff   = rem_sh - {1'b0, per_q};
  assign fits   = (rem_sh >= {1'b0, per_q});

  assign duty_prod = ProdBits'(high_q) * ProdBits'(pfdm_pkg::DutyScale);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= pfdm_pkg::ClockResetHz;
      prev_q  <= 1'b1;
      cnt_q   <= '0;
    end else begin
      if (cfg_we_i) clock_q <= cfg_wdata_i;
      if (cmd_i.accept) begin
        prev_q <= level_i;
        cnt_q  <= cmd_i.clr_cnt ? '0 : cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_rise) rise_q <= cnt_q;
    if (cmd_i.cap_fall) fall_q <= cnt_q;
    if (cmd_i.cap_second) begin
      per_q  <= cnt_q - rise_q;
      high_q <= fall_q - rise_q;
    end
    if (cmd_i.load_freq) begin
      quo_q <= DivBits'(clock_q);
      rem_q <= '0;
      oor_q <= 1'b0;
    end else if (cmd_i.load_duty) begin
      quo_q <= DivBits'(duty_prod);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[DivBits-2:0], fits};
      rem_q <= fits ? diff[CB-1:0] : rem_sh[CB-1:0];
    end
    if (cmd_i.set_invalid) begin
      freq_q <= '0;
      duty_q <= '0;
      oor_q  <= 1'b1;
    end
    if (cmd_i.save_freq) freq_q <= quo_q[pfdm_pkg::FreqBits-1:0];
    if (cmd_i.save_duty) duty_q <= quo_q[pfdm_pkg::DutyBits-1:0];
  end

  assign freq_o = freq_q;
  assign duty_o = duty_q;
  assign oor_o  = oor_q;

endmodule

`default_nettype wire
